FILE: rtl/core/swap_transition_parse_engine_assert.svh
// Assertion macros for the transition parse engine.
// Used by swap_transition_parse_engine.sv; each macro expects clk and rst_n in scope.
`ifndef SWAP_TRANSITION_PARSE_ENGINE_ASSERT_SVH
`define SWAP_TRANSITION_PARSE_ENGINE_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define STPE_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the same cycle.
`define STPE_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define STPE_FOLLOWS(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/stpe_pkg.sv
// Shared types and constants for the transition parse engine.
// No dependencies; imported by the stack, buffer and top-level modules.
package stpe_pkg;

    localparam int MAX_WORDS_DEF = 64;

    typedef enum logic [2:0] {
        FN_START = 3'd0,
        FN_SHIFT = 3'd1,
        FN_SWAP  = 3'd2,
        FN_LEFT  = 3'd3,
        FN_RIGHT = 3'd4
    } func_e;

    typedef enum logic [1:0] {
        STK_CLEAR = 2'd0,
        STK_PUSH  = 2'd1,
        STK_SWAP  = 2'd2,
        STK_ARC   = 2'd3
    } stk_op_e;

    typedef enum logic [1:0] {
        BUF_LOAD = 2'd0,
        BUF_POP  = 2'd1,
        BUF_PUSH = 2'd2
    } buf_op_e;

    typedef struct packed {
        logic    en;
        stk_op_e op;
    } stk_cmd_t;

    typedef struct packed {
        logic    en;
        buf_op_e op;
    } buf_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic [6:0] num_words;
        logic [7:0] label;
    } act_item_t;

    typedef struct packed {
        logic       accepted;
        logic       forbidden;
        logic       arc_valid;
        logic [5:0] dep_index;
        logic [5:0] head_index;
        logic [7:0] arc_label;
        logic [6:0] stack_words;
        logic [6:0] buffer_words;
        logic       done_res;
    } res_item_t;

endpackage

FILE: rtl/core/swap_transition_parse_engine.sv
// Top level of the transition parse engine: input register, action decode,
// stack and buffer units, result register. Depends on stpe_pkg, stpe_stack,
// stpe_buffer and swap_transition_parse_engine_assert.svh.
//
//  channel | valid     | stall     | payload            | item
//  --------+-----------+-----------+--------------------+-------------------------
//  act     | act_valid | act_stall | act (act_item_t)   | one parser action
//  res     | res_valid | res_stall | res (res_item_t)   | one result per action
//
// One item enters per cycle while act_stall is low; its result leaves after passing
// through the input register and then the result register.
// Each action reads only the counts, both stack registers and the buffer front, and
// the memory read behind each unit is issued at the same edge for the next item.
// A stall on res fills the result register, then the input register, then
// raises act_stall; the input register takes one more item while the result waits.
// Reset clears the valid flags and the counts; the word memories need no clearing.
module swap_transition_parse_engine #(
    parameter int MAX_WORDS = stpe_pkg::MAX_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                act_valid,
    output logic                act_stall,
    input  stpe_pkg::act_item_t act,
    output logic                res_valid,
    input  logic                res_stall,
    output stpe_pkg::res_item_t res
);
    import stpe_pkg::*;

    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int WW = $clog2(MAX_WORDS);

    // Input register.
    logic      s1_valid_reg, s1_valid_next;
    act_item_t s1_reg;

    // Result register.
    logic      res_valid_reg, res_valid_next;
    res_item_t res_reg, res_next;

    logic      out_free;
    logic      advance;
    logic      act_take;

    // Unit interfaces.
    stk_cmd_t          stk_cmd;
    buf_cmd_t          buf_cmd;
    logic [CW-1:0]     stk_count;
    logic [CW-1:0]     buf_count;
    logic [WW-1:0]     stk_top;
    logic [WW-1:0]     stk_sec;
    logic [WW-1:0]     buf_front;
    logic [WW-1:0]     head_w;
    logic [WW-1:0]     dep_w;

    logic [CW-1:0]     len_sat;
    logic [CW-1:0]     sc_after;
    logic [CW-1:0]     bc_after;
    logic              acc;
    logic              forb;
    logic              arc;
    logic              stk_push;

    // Handshake: the result register frees when it is empty or being taken.
    assign out_free  = !res_valid_reg || !res_stall;
    assign advance   = s1_valid_reg && out_free;
    assign act_stall = s1_valid_reg && !out_free;
    assign act_take  = act_valid && !act_stall;

    always_comb
    begin
        if (act_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // A sentence longer than the stores is cut to their size.
    always_comb
    begin
        if (int'(s1_reg.num_words) > MAX_WORDS)
        begin
            len_sat = CW'(MAX_WORDS);
        end
        else
        begin
            len_sat = CW'(s1_reg.num_words);
        end
    end

    // Forbidding rules, taken on the state before the action. The rules
    // count a guard entry on each side, which is folded into the constants.
    always_comb
    begin
        forb = 1'b0;
        unique case (s1_reg.func)
            FN_START:
            begin
                forb = 1'b0;
            end
            FN_SHIFT:
            begin
                forb = (buf_count == '0) ||
                       ((buf_count == CW'(1)) && (stk_count > CW'(1)));
            end
            FN_SWAP:
            begin
                forb = (stk_count < CW'(2)) || (stk_sec > stk_top);
            end
            FN_LEFT:
            begin
                forb = (stk_count < CW'(2));
            end
            FN_RIGHT:
            begin
                forb = (stk_count < CW'(2)) ||
                       ((buf_count == '0) && (stk_count == CW'(2)));
            end
            default:
            begin
                forb = 1'b1;
            end
        endcase
    end

    // Action decode. A refused action leaves both units untouched.
    always_comb
    begin
        acc         = 1'b0;
        arc         = 1'b0;
        stk_cmd.en  = 1'b0;
        stk_cmd.op  = STK_PUSH;
        buf_cmd.en  = 1'b0;
        buf_cmd.op  = BUF_POP;
        sc_after    = stk_count;
        bc_after    = buf_count;
        unique case (s1_reg.func) inside
            FN_START:
            begin
                acc        = 1'b1;
                stk_cmd.op = STK_CLEAR;
                buf_cmd.op = BUF_LOAD;
                sc_after   = '0;
                bc_after   = len_sat;
            end
            FN_SHIFT:
            begin
                acc        = (buf_count != '0) && (stk_count < CW'(MAX_WORDS));
                stk_cmd.op = STK_PUSH;
                buf_cmd.op = BUF_POP;
                if (acc)
                begin
                    sc_after = stk_count + CW'(1);
                    bc_after = buf_count - CW'(1);
                end
            end
            FN_SWAP:
            begin
                acc        = (stk_count >= CW'(2)) && (buf_count < CW'(MAX_WORDS));
                stk_cmd.op = STK_SWAP;
                buf_cmd.op = BUF_PUSH;
                if (acc)
                begin
                    sc_after = stk_count - CW'(1);
                    bc_after = buf_count + CW'(1);
                end
            end
            FN_LEFT, FN_RIGHT:
            begin
                acc        = (stk_count >= CW'(2));
                arc        = acc;
                stk_cmd.op = STK_ARC;
                if (acc)
                begin
                    sc_after = stk_count - CW'(1);
                end
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase
        stk_cmd.en = advance && acc;
        buf_cmd.en = advance && acc && !arc;
    end

    // Right arc keeps the second word as head; left arc keeps the top.
    assign head_w = (s1_reg.func == FN_RIGHT) ? stk_sec : stk_top;
    assign dep_w  = (s1_reg.func == FN_RIGHT) ? stk_top : stk_sec;

    always_comb
    begin
        res_next.accepted     = acc;
        res_next.forbidden    = forb;
        res_next.arc_valid    = arc;
        res_next.dep_index    = arc ? 6'(dep_w) : 6'd0;
        res_next.head_index   = arc ? 6'(head_w) : 6'd0;
        res_next.arc_label    = arc ? s1_reg.label : 8'd0;
        res_next.stack_words  = 7'(sc_after);
        res_next.buffer_words = 7'(bc_after);
        res_next.done_res     = (bc_after == '0) && (sc_after == CW'(1));
    end

    stpe_stack #(
        .MAX_WORDS (MAX_WORDS)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (stk_cmd),
        .push_word (buf_front),
        .head_word (head_w),
        .count     (stk_count),
        .top       (stk_top),
        .sec       (stk_sec)
    );

    stpe_buffer #(
        .MAX_WORDS (MAX_WORDS)
    ) u_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (buf_cmd),
        .load_len  (len_sat),
        .push_word (stk_sec),
        .count     (buf_count),
        .front     (buf_front)
    );

    always_ff @(posedge clk)
    begin
        if (act_take)
        begin
            s1_reg <= act;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Checks on the engine's own logic.
    assign stk_push = stk_cmd.en && (stk_cmd.op == STK_PUSH);

`include "swap_transition_parse_engine_assert.svh"

    `STPE_ALWAYS(a_stack_bound, stk_count <= CW'(MAX_WORDS), "stack count above capacity")
    `STPE_IMPLIES(a_stall_needs_item, act_stall, s1_valid_reg, "stall with empty input register")
    `STPE_FOLLOWS(a_advance_gives_result, advance, res_valid_reg, "advanced item has no result")
    `STPE_FOLLOWS(a_push_grows, stk_push, stk_count == $past(stk_count) + CW'(1), "push lost")

endmodule

FILE: rtl/core/stpe_stack.sv
// Parser stack: top two words in registers, full contents in a memory.
// Depends on stpe_pkg for the command type.
module stpe_stack #(
    parameter int MAX_WORDS = stpe_pkg::MAX_WORDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stpe_pkg::stk_cmd_t               cmd,
    input  logic [$clog2(MAX_WORDS)-1:0]     push_word,
    input  logic [$clog2(MAX_WORDS)-1:0]     head_word,
    output logic [$clog2(MAX_WORDS+1)-1:0]   count,
    output logic [$clog2(MAX_WORDS)-1:0]     top,
    output logic [$clog2(MAX_WORDS)-1:0]     sec
);
    import stpe_pkg::*;

    localparam int AW = $clog2(MAX_WORDS);
    localparam int CW = $clog2(MAX_WORDS + 1);

    logic [AW-1:0] mem [MAX_WORDS];

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] top_reg, top_next;
    logic [AW-1:0] sec_reg, sec_next;
    logic [AW-1:0] rd_reg;

    logic          wr_en;
    logic [CW-1:0] wr_sum;
    logic [AW-1:0] wr_data;
    logic [CW-1:0] rd_sum;

    // The registered read always holds the entry just below the second word.
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        sec_next   = sec_reg;
        wr_en      = 1'b0;
        wr_sum     = count_reg - CW'(2);
        wr_data    = top_reg;
        if (cmd.en)
        begin
            unique case (cmd.op)
                STK_CLEAR:
                begin
                    count_next = '0;
                end
                STK_PUSH:
                begin
                    count_next = count_reg + CW'(1);
                    top_next   = push_word;
                    sec_next   = top_reg;
                    wr_en      = 1'b1;
                    wr_sum     = count_reg;
                    wr_data    = push_word;
                end
                STK_SWAP:
                begin
                    count_next = count_reg - CW'(1);
                    sec_next   = rd_reg;
                    wr_en      = 1'b1;
                    wr_data    = top_reg;
                end
                STK_ARC:
                begin
                    count_next = count_reg - CW'(1);
                    top_next   = head_word;
                    sec_next   = rd_reg;
                    wr_en      = 1'b1;
                    wr_data    = head_word;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign rd_sum = count_next - CW'(3);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_sum[AW-1:0]] <= wr_data;
        end
        if (cmd.en)
        begin
            rd_reg  <= mem[rd_sum[AW-1:0]];
            top_reg <= top_next;
            sec_reg <= sec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;
    assign top   = top_reg;
    assign sec   = sec_reg;

endmodule

FILE: rtl/core/stpe_buffer.sv
// Parser buffer: front word in a register, swapped-back words in a memory.
// Entries below the low-water mark are still the initial fill and are computed.
// Depends on stpe_pkg for the command type.
module stpe_buffer #(
    parameter int MAX_WORDS = stpe_pkg::MAX_WORDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stpe_pkg::buf_cmd_t               cmd,
    input  logic [$clog2(MAX_WORDS+1)-1:0]   load_len,
    input  logic [$clog2(MAX_WORDS)-1:0]     push_word,
    output logic [$clog2(MAX_WORDS+1)-1:0]   count,
    output logic [$clog2(MAX_WORDS)-1:0]     front
);
    import stpe_pkg::*;

    localparam int AW = $clog2(MAX_WORDS);
    localparam int CW = $clog2(MAX_WORDS + 1);

    logic [AW-1:0] mem [MAX_WORDS];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] low_reg, low_next;
    logic [CW-1:0] len_reg, len_next;
    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] rd_reg;

    logic [CW-1:0] count_dec;
    logic [CW-1:0] orig_word;
    logic          below_low;
    logic          wr_en;
    logic [CW-1:0] rd_sum;

    assign count_dec = count_reg - CW'(1);
    assign orig_word = len_reg - count_reg + CW'(1);
    assign below_low = ({1'b0, count_reg} < ({1'b0, low_reg} + (CW + 1)'(2)));

    always_comb
    begin
        count_next = count_reg;
        low_next   = low_reg;
        len_next   = len_reg;
        front_next = front_reg;
        wr_en      = 1'b0;
        if (cmd.en)
        begin
            unique case (cmd.op)
                BUF_LOAD:
                begin
                    count_next = load_len;
                    low_next   = load_len;
                    len_next   = load_len;
                    front_next = '0;
                end
                BUF_POP:
                begin
                    count_next = count_dec;
                    low_next   = (count_dec < low_reg) ? count_dec : low_reg;
                    front_next = below_low ? orig_word[AW-1:0] : rd_reg;
                end
                BUF_PUSH:
                begin
                    count_next = count_reg + CW'(1);
                    front_next = push_word;
                    wr_en      = 1'b1;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign rd_sum = count_next - CW'(2);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= push_word;
        end
        if (cmd.en)
        begin
            rd_reg    <= mem[rd_sum[AW-1:0]];
            front_reg <= front_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            low_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
        end
    end

    assign count = count_reg;
    assign front = front_reg;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for swap_transition_parse_engine: parser actions go in on the act
// channel; each result is checked against a hand-typed row or a transition-state predictor.
// Depends on stpe_pkg and the engine RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stpe_pkg::*;

    localparam int MAX_WORDS = MAX_WORDS_DEF;

    // The random part stops once this many items have been accepted in total.
    localparam int unsigned ITEM_TARGET = 1100;

    // Watchdog limit in clock cycles. The worst correct run, with long gaps and long stalls
    // on every item, stays far below this value.
    localparam int unsigned CYCLE_LIMIT = 500000;

    // Function codes with no defined action. The engine must refuse them.
    localparam logic [2:0] FN_RSVD_5 = 3'd5;
    localparam logic [2:0] FN_RSVD_6 = 3'd6;
    localparam logic [2:0] FN_RSVD_7 = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      act_valid;
    logic      act_stall;
    act_item_t act;
    logic      res_valid;
    logic      res_stall;
    res_item_t res;

    swap_transition_parse_engine #(
        .MAX_WORDS(MAX_WORDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .act_valid(act_valid),
        .act_stall(act_stall),
        .act      (act),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    // One row of the directed part. When typed is set, want holds the result written out
    // by hand, and the predictor only tracks the state.
    typedef struct {
        act_item_t item;
        bit        typed;
        res_item_t want;
    } dir_row_t;

    dir_row_t    dir_rows[$];
    res_item_t   pending_results[$];
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count   = 0;
    bit          tx_calm      = 1'b0;
    bit          rx_calm      = 1'b0;

    // Predictor state: the word stack (bottom at index 0) and the word buffer (front at
    // the highest used index). Both are plain copies of what the engine should hold.
    logic [5:0]  stack_mem [MAX_WORDS];
    logic [5:0]  buffer_mem[MAX_WORDS];
    int unsigned stack_depth  = 0;
    int unsigned buffer_depth = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The forbidding rules look at the state before the action. They count one guard entry
    // on each of stack and buffer, hence the +1 on both depths.
    function automatic bit is_forbidden(input logic [2:0] fn);
        int unsigned s;
        int unsigned b;
        s = stack_depth + 1;
        b = buffer_depth + 1;
        if (fn == FN_START)
            return 1'b0;
        if (fn > FN_RIGHT)
            return 1'b1;
        if (fn == FN_SHIFT)
            return (b == 1) || (b == 2 && s > 2);
        // Swap is forbidden when it would move a larger word behind a smaller one.
        if (fn == FN_SWAP && s >= 3 && stack_mem[stack_depth - 2] > stack_mem[stack_depth - 1])
            return 1'b1;
        if (s < 3)
            return 1'b1;
        return fn == FN_RIGHT && b == 1 && s == 3;
    endfunction

    // Applies one action to the predictor state and returns the result it should cause.
    // Structurally impossible actions are refused and leave the state alone.
    function automatic res_item_t apply_action(input act_item_t it);
        res_item_t   r;
        int unsigned n;
        logic [5:0]  top;
        logic [5:0]  sec;
        r = '0;
        r.forbidden = is_forbidden(it.func);
        case (it.func) inside
            FN_START:
            begin
                n = (it.num_words > MAX_WORDS) ? MAX_WORDS : it.num_words;
                for (int unsigned i = 0; i < n; i++)
                    buffer_mem[i] = 6'(n - 1 - i);
                buffer_depth = n;
                stack_depth  = 0;
                r.accepted   = 1'b1;
            end
            FN_SHIFT:
            begin
                if (buffer_depth > 0 && stack_depth < MAX_WORDS)
                begin
                    buffer_depth--;
                    stack_mem[stack_depth] = buffer_mem[buffer_depth];
                    stack_depth++;
                    r.accepted = 1'b1;
                end
            end
            FN_SWAP:
            begin
                if (stack_depth >= 2 && buffer_depth < MAX_WORDS)
                begin
                    top = stack_mem[stack_depth - 1];
                    sec = stack_mem[stack_depth - 2];
                    buffer_mem[buffer_depth] = sec;
                    buffer_depth++;
                    stack_mem[stack_depth - 2] = top;
                    stack_depth--;
                    r.accepted = 1'b1;
                end
            end
            FN_LEFT, FN_RIGHT:
            begin
                if (stack_depth >= 2)
                begin
                    top = stack_mem[stack_depth - 1];
                    sec = stack_mem[stack_depth - 2];
                    r.dep_index  = (it.func == FN_RIGHT) ? top : sec;
                    r.head_index = (it.func == FN_RIGHT) ? sec : top;
                    stack_mem[stack_depth - 2] = r.head_index;
                    stack_depth--;
                    r.accepted  = 1'b1;
                    r.arc_valid = 1'b1;
                    r.arc_label = it.label;
                end
            end
            default:
            begin
            end
        endcase
        r.stack_words  = 7'(stack_depth);
        r.buffer_words = 7'(buffer_depth);
        r.done_res     = (buffer_depth == 0 && stack_depth == 1);
        return r;
    endfunction

    function automatic act_item_t action(input logic [2:0] fn, input logic [6:0] len,
                                         input logic [7:0] lab);
        act_item_t a;
        a.func      = fn;
        a.num_words = len;
        a.label     = lab;
        return a;
    endfunction

    // A result without an arc, for rows whose outcome is plain to see.
    function automatic res_item_t plain_result(input bit acc, input bit forb,
                                               input int unsigned sw, input int unsigned bw,
                                               input bit done);
        res_item_t r;
        r = '0;
        r.accepted     = acc;
        r.forbidden    = forb;
        r.stack_words  = 7'(sw);
        r.buffer_words = 7'(bw);
        r.done_res     = done;
        return r;
    endfunction

    function automatic string fmt_result(input res_item_t r);
        return $sformatf({"{acc %0d forb %0d arc %0d dep %0d head %0d label %0d",
                          " stack %0d buf %0d done %0d}"},
                         r.accepted, r.forbidden, r.arc_valid, r.dep_index, r.head_index,
                         r.arc_label, r.stack_words, r.buffer_words, r.done_res);
    endfunction

    task automatic add_row(input act_item_t a, input bit typed, input res_item_t want);
        dir_row_t row;
        row.item  = a;
        row.typed = typed;
        row.want  = want;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    function automatic int unsigned idle_length();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(1, 3);
        if (p < 93)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Offers one item and returns at the edge where it is accepted, with valid still high.
    // A gap lowers valid first, so valid never falls and rises within one time step.
    // The expected result is queued at the moment of acceptance.
    task automatic send(input act_item_t it, input bit typed = 1'b0,
                        input res_item_t typed_res = '0);
        int unsigned gap;
        res_item_t   predicted;
        if ($urandom_range(0, 149) == 0)
            tx_calm = !tx_calm;
        gap = (!tx_calm && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0)
        begin
            act_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        act       <= it;
        act_valid <= 1'b1;
        do
            @(posedge clk);
        while (act_stall);
        predicted = apply_action(it);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        items_sent++;
    endtask

    // Holds the sender off until every queued result has come back. It must be called
    // right after send returns, at the edge of acceptance.
    task automatic drain();
        act_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One sentence from start to completion. Most steps are structurally sound, so the
    // parse reaches the deep states; now and then a random arc or swap breaks it. Swaps
    // are only taken in the unforbidden direction and are capped, so the sentence ends.
    task automatic parse_sentence();
        int unsigned len;
        int unsigned pick;
        int unsigned steps;
        int unsigned swaps;
        logic [2:0]  fn;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            len = 0;
        else if (pick < 80)
            len = $urandom_range(1, 10);
        else if (pick < 95)
            len = $urandom_range(11, MAX_WORDS);
        else
            len = $urandom_range(MAX_WORDS + 1, 127);
        send(action(FN_START, 7'(len), 8'($urandom)));
        steps = 0;
        swaps = 0;
        while (!(buffer_depth == 0 && stack_depth <= 1) && steps < 4 * len + 8)
        begin
            if ($urandom_range(0, 19) == 0)
                fn = 3'($urandom_range(FN_SHIFT, FN_RIGHT));
            else if (buffer_depth > 0 && (stack_depth < 2 || $urandom_range(0, 1) == 0))
                fn = FN_SHIFT;
            else if (swaps < len && $urandom_range(0, 4) == 0
                     && stack_mem[stack_depth - 2] < stack_mem[stack_depth - 1])
            begin
                fn = FN_SWAP;
                swaps++;
            end
            else
                fn = $urandom_range(0, 1) ? FN_LEFT : FN_RIGHT;
            send(action(fn, 7'($urandom), 8'($urandom)));
            steps++;
        end
    endtask

    task automatic check_result(input res_item_t got);
        res_item_t want;
        string     diff;
        if (pending_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result with none pending: %s", fmt_result(got));
            return;
        end
        want = pending_results.pop_front();
        diff = "";
        if (got.accepted !== want.accepted)         diff = {diff, " accepted"};
        if (got.forbidden !== want.forbidden)       diff = {diff, " forbidden"};
        if (got.arc_valid !== want.arc_valid)       diff = {diff, " arc_valid"};
        if (got.dep_index !== want.dep_index)       diff = {diff, " dep_index"};
        if (got.head_index !== want.head_index)     diff = {diff, " head_index"};
        if (got.arc_label !== want.arc_label)       diff = {diff, " arc_label"};
        if (got.stack_words !== want.stack_words)   diff = {diff, " stack_words"};
        if (got.buffer_words !== want.buffer_words) diff = {diff, " buffer_words"};
        if (got.done_res !== want.done_res)         diff = {diff, " done_res"};
        if (diff != "")
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result %0d differs in%s: expected %s, got %s",
                         results_seen, diff, fmt_result(want), fmt_result(got));
        end
        results_seen++;
    endtask

    // Result side: checks every accepted result and drives res_stall. Stall runs come in
    // bursts of random length, with calm stretches in between where nothing is stalled.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        res_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                check_result(res);
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    rx_calm = !rx_calm;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                begin
                    stall_left = idle_length() - 1;
                    res_stall <= 1'b1;
                end
                else
                    res_stall <= 1'b0;
            end
        end
    end

    // Watchdog: this counts clock cycles and gives up when the limit is reached.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus.
    initial
    begin
        int unsigned burst;
        act_valid = 1'b0;
        act       = '0;
        rst_n     = 1'b0;

        // Directed part. After reset every action except start is refused and flagged by
        // the rules, and so are the undefined function codes.
        add_row(action(FN_SHIFT, 7'd0, 8'h00), 1'b1, plain_result(0, 1, 0, 0, 0));
        add_row(action(FN_SWAP, 7'd0, 8'h00), 1'b1, plain_result(0, 1, 0, 0, 0));
        add_row(action(FN_LEFT, 7'd0, 8'hff), 1'b1, plain_result(0, 1, 0, 0, 0));
        add_row(action(FN_RIGHT, 7'd0, 8'hff), 1'b1, plain_result(0, 1, 0, 0, 0));
        add_row(action(FN_RSVD_5, 7'd0, 8'h00), 1'b1, plain_result(0, 1, 0, 0, 0));
        add_row(action(FN_RSVD_6, 7'd127, 8'hff), 1'b1, plain_result(0, 1, 0, 0, 0));
        add_row(action(FN_RSVD_7, 7'd64, 8'h5a), 1'b1, plain_result(0, 1, 0, 0, 0));
        // An empty sentence, then a shift on its empty buffer.
        add_row(action(FN_START, 7'd0, 8'hff), 1'b1, plain_result(1, 0, 0, 0, 0));
        add_row(action(FN_SHIFT, 7'd0, 8'h00), 1'b1, plain_result(0, 1, 0, 0, 0));
        // A length beyond the word limit saturates.
        add_row(action(FN_START, 7'd127, 8'h00), 1'b1, plain_result(1, 0, 0, 64, 0));
        // A short sentence that runs through both swap verdicts, a pop with one word on
        // the stack, a right arc flagged by the rules, both arcs and the final done state.
        add_row(action(FN_START, 7'd3, 8'h00), 1'b1, plain_result(1, 0, 0, 3, 0));
        add_row(action(FN_SHIFT, 7'd0, 8'h00), 1'b0, '0);
        add_row(action(FN_LEFT, 7'd0, 8'h11), 1'b0, '0);
        add_row(action(FN_SHIFT, 7'd0, 8'h00), 1'b0, '0);
        add_row(action(FN_SWAP, 7'd0, 8'h00), 1'b0, '0);
        add_row(action(FN_SHIFT, 7'd0, 8'h00), 1'b0, '0);
        add_row(action(FN_SWAP, 7'd0, 8'h00), 1'b0, '0);
        add_row(action(FN_SHIFT, 7'd0, 8'h00), 1'b0, '0);
        add_row(action(FN_LEFT, 7'd0, 8'hff), 1'b0, '0);
        add_row(action(FN_SHIFT, 7'd0, 8'h00), 1'b0, '0);
        add_row(action(FN_RIGHT, 7'd0, 8'h00), 1'b0, '0);
        add_row(action(FN_RIGHT, 7'd0, 8'h5a), 1'b0, '0);
        // The longest sentence, and a restart in the middle of a parse.
        add_row(action(FN_START, 7'd64, 8'h00), 1'b1, plain_result(1, 0, 0, 64, 0));
        add_row(action(FN_SHIFT, 7'd0, 8'h00), 1'b0, '0);
        add_row(action(FN_START, 7'd1, 8'h00), 1'b1, plain_result(1, 0, 0, 1, 0));
        add_row(action(FN_SHIFT, 7'd0, 8'h00), 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // Random part: mostly complete sentences with random labels and lengths, with
        // bursts of arbitrary items in between. Now and then the sender waits for all
        // results to come back.
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                burst = $urandom_range(1, 5);
                repeat (burst)
                    send(action(3'($urandom_range(0, 7)), 7'($urandom), 8'($urandom)));
            end
            else
            begin
                parse_sentence();
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: swap_transition_parse_engine.f
+incdir+rtl/core
rtl/core/stpe_pkg.sv
rtl/core/stpe_stack.sv
rtl/core/stpe_buffer.sv
rtl/core/swap_transition_parse_engine.sv
sim/tb_top.sv
